// File: sv/pfi_pkg.sv
package pfi_pkg;

  // Defaults for the top level parameters.
  localparam int CAPACITY_DEF    = 16;
  localparam int MAX_DIM_DEF     = 8;
  localparam int COORD_WIDTH_DEF = 32;

  // Queue entry fields are sized for the largest MAX_DIM (64).
  localparam int POS_W     = 6;
  localparam int LEN_MAX_W = 7;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [3:0] VLEN_RESET = 4'd4;

  // Register index, taken from paddr[2].
  localparam logic REG_VECTOR_LENGTH = 1'b0;

  // Operation codes of an input word.
  localparam logic [1:0] OP_COORD = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]          operation;
    logic signed [31:0]  coord_value;
    logic [3:0]          entry_index;
    logic [2:0]          coord_index;
  } in_item_t;

  typedef struct packed {
    logic                inserted;
    logic [4:0]          removed_count;
    logic                overflow;
    logic [4:0]          occupancy;
    logic signed [31:0]  read_value;
    logic                read_valid;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_COORD,
    CMD_LAST,
    CMD_READ,
    CMD_CLEAR
  } cmd_t;

  typedef struct packed {
    cmd_t                  cmd;
    in_item_t              item;
    logic [POS_W-1:0]      pos;
    logic [LEN_MAX_W-1:0]  len;
  } q_entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SLOT,
    B_READ,
    B_CMP,
    B_FINISH,
    B_WRITE,
    B_RDOUT
  } back_state_t;

endpackage

// File: sv/pfi_front.sv
module pfi_front #(
  parameter int MAX_DIM = pfi_pkg::MAX_DIM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               q_full,
  input  pfi_pkg::in_item_t  in_item,
  input  logic [3:0]         vector_length,
  output logic               q_push,
  output pfi_pkg::q_entry_t  q_din
);
  import pfi_pkg::*;

  localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [DIM_W-1:0] counter_r, counter_nxt;
  int               eff_len;
  logic             accept;
  logic             last;

  always_comb begin
    if (vector_length == 4'd0) begin
      eff_len = 1;
    end else if (int'(vector_length) > MAX_DIM) begin
      eff_len = MAX_DIM;
    end else begin
      eff_len = int'(vector_length);
    end
  end

  assign accept = start && !q_full;
  assign last   = (int'(counter_r) + 1) >= eff_len;

  always_comb begin
    counter_nxt    = counter_r;
    q_push         = 1'b0;
    q_din.cmd      = CMD_COORD;
    q_din.item     = in_item;
    q_din.pos      = POS_W'(counter_r);
    q_din.len      = LEN_MAX_W'(eff_len);
    if (accept) begin
      case (in_item.operation)
        OP_COORD: begin
          q_push = 1'b1;
          if (last) begin
            q_din.cmd   = CMD_LAST;
            counter_nxt = '0;
          end else begin
            counter_nxt = counter_r + DIM_W'(1);
          end
        end
        OP_READ: begin
          q_push    = 1'b1;
          q_din.cmd = CMD_READ;
        end
        OP_CLEAR: begin
          q_push      = 1'b1;
          q_din.cmd   = CMD_CLEAR;
          counter_nxt = '0;
        end
        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
    end else begin
      counter_r <= counter_nxt;
    end
  end

endmodule

// File: sv/pfi_queue.sv
module pfi_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pfi_pkg::q_entry_t  din,
  input  logic               pop,
  output pfi_pkg::q_entry_t  dout,
  output logic               full,
  output logic               empty
);
  import pfi_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: sv/pfi_back.sv
module pfi_back #(
  parameter int CAPACITY    = pfi_pkg::CAPACITY_DEF,
  parameter int MAX_DIM     = pfi_pkg::MAX_DIM_DEF,
  parameter int COORD_WIDTH = pfi_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  pfi_pkg::q_entry_t   q_dout,
  output logic                q_pop,
  output logic                out_strobe,
  output pfi_pkg::out_item_t  out_item
);
  import pfi_pkg::*;

  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int LEN_W  = $clog2(MAX_DIM + 1);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int DEPTH  = CAPACITY * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef logic [COORD_WIDTH-1:0] coord_t;

  function automatic logic [ADDR_W-1:0] addr_of(logic [SLOT_W-1:0] s, logic [DIM_W-1:0] c);
    return ADDR_W'(s) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
  endfunction

  back_state_t       state_r, state_nxt;
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic [CNT_W-1:0]  removed_r, removed_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W-1:0] dest_r, dest_nxt;
  logic [DIM_W-1:0]  crd_r, crd_nxt;
  logic [DIM_W-1:0]  pidx_r, pidx_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              cle_r, cle_nxt;
  logic              ele_r, ele_nxt;
  logic              pend_r, pend_nxt;
  logic              keep_r, keep_nxt;
  logic              found_r, found_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              rd_cok_r, rd_cok_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  out_item_t         out_r, out_nxt;
  coord_t            cand_r [MAX_DIM];
  coord_t            cand_nxt [MAX_DIM];

  coord_t            mem [DEPTH];
  coord_t            mem_q_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  coord_t            mem_wdata;

  coord_t            cand_sel;
  logic              c_gt, c_lt, cle_cur, ele_cur;
  logic              slot_last;
  logic [SLOT_W-1:0] e_idx;
  logic [DIM_W-1:0]  c_idx;
  logic              e_ok;
  logic              c_ok;

  // Compare stage: the memory word read in the previous cycle against the
  // matching candidate coordinate.
  assign cand_sel  = cand_r[pidx_r];
  assign c_gt      = $signed(cand_sel) > $signed(mem_q_r);
  assign c_lt      = $signed(cand_sel) < $signed(mem_q_r);
  assign cle_cur   = cle_r && !c_gt;
  assign ele_cur   = ele_r && !c_lt;
  assign slot_last = (slot_r == SLOT_W'(CAPACITY - 1));

  assign e_idx = SLOT_W'(q_dout.item.entry_index);
  assign c_idx = DIM_W'(q_dout.item.coord_index);
  assign e_ok  = int'(q_dout.item.entry_index) < CAPACITY;
  assign c_ok  = int'(q_dout.item.coord_index) < MAX_DIM;

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    occ_nxt        = occ_r;
    removed_nxt    = removed_r;
    slot_nxt       = slot_r;
    dest_nxt       = dest_r;
    crd_nxt        = crd_r;
    pidx_nxt       = pidx_r;
    len_nxt        = len_r;
    cle_nxt        = cle_r;
    ele_nxt        = ele_r;
    pend_nxt       = 1'b0;
    keep_nxt       = keep_r;
    found_nxt      = found_r;
    rd_ok_nxt      = rd_ok_r;
    rd_cok_nxt     = rd_cok_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = '0;
    cand_nxt       = cand_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = addr_of(dest_r, crd_r);
    mem_raddr      = addr_of(slot_r, crd_r);
    mem_wdata      = (LEN_W'(crd_r) < len_r) ? cand_r[crd_r] : '0;

    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_dout.cmd)
            CMD_COORD: begin
              cand_nxt[DIM_W'(q_dout.pos)] = COORD_WIDTH'(q_dout.item.coord_value);
            end
            CMD_LAST: begin
              cand_nxt[DIM_W'(q_dout.pos)] = COORD_WIDTH'(q_dout.item.coord_value);
              len_nxt     = LEN_W'(q_dout.len);
              slot_nxt    = '0;
              found_nxt   = 1'b0;
              keep_nxt    = 1'b1;
              removed_nxt = '0;
              state_nxt   = B_SLOT;
            end
            CMD_READ: begin
              rd_ok_nxt  = e_ok && valid_r[e_idx];
              rd_cok_nxt = c_ok;
              mem_raddr  = addr_of(e_idx, c_idx);
              mem_re     = e_ok && c_ok;
              state_nxt  = B_RDOUT;
            end
            CMD_CLEAR: begin
              valid_nxt      = '0;
              occ_nxt        = '0;
              out_strobe_nxt = 1'b1;
            end
            default: begin
              state_nxt = B_IDLE;
            end
          endcase
        end
      end

      B_SLOT: begin
        if (!valid_r[slot_r]) begin
          if (!found_r) begin
            found_nxt = 1'b1;
            dest_nxt  = slot_r;
          end
          if (slot_last) begin
            state_nxt = B_FINISH;
          end else begin
            slot_nxt = slot_r + SLOT_W'(1);
          end
        end else begin
          crd_nxt   = '0;
          cle_nxt   = 1'b1;
          ele_nxt   = 1'b1;
          state_nxt = B_READ;
        end
      end

      B_READ: begin
        mem_re   = 1'b1;
        pend_nxt = 1'b1;
        pidx_nxt = crd_r;
        if (pend_r) begin
          cle_nxt = cle_cur;
          ele_nxt = ele_cur;
        end
        if (LEN_W'(crd_r) == len_r - LEN_W'(1)) begin
          state_nxt = B_CMP;
        end else begin
          crd_nxt = crd_r + DIM_W'(1);
        end
      end

      B_CMP: begin
        // An equal entry dominates the candidate, so that test comes first.
        if (cle_cur) begin
          keep_nxt = 1'b0;
        end else if (ele_cur) begin
          valid_nxt[slot_r] = 1'b0;
          removed_nxt       = removed_r + CNT_W'(1);
          occ_nxt           = occ_r - CNT_W'(1);
          if (!found_r) begin
            found_nxt = 1'b1;
            dest_nxt  = slot_r;
          end
        end
        if (slot_last) begin
          state_nxt = B_FINISH;
        end else begin
          slot_nxt  = slot_r + SLOT_W'(1);
          state_nxt = B_SLOT;
        end
      end

      B_FINISH: begin
        if (keep_r && found_r) begin
          crd_nxt   = '0;
          state_nxt = B_WRITE;
        end else begin
          out_strobe_nxt        = 1'b1;
          out_nxt.overflow      = keep_r;
          out_nxt.removed_count = 5'(removed_r);
          out_nxt.occupancy     = 5'(occ_r);
          state_nxt             = B_IDLE;
        end
      end

      B_WRITE: begin
        // Coordinates beyond the length are written as zero.
        mem_we = 1'b1;
        if (crd_r == DIM_W'(MAX_DIM - 1)) begin
          valid_nxt[dest_r]     = 1'b1;
          occ_nxt               = occ_r + CNT_W'(1);
          out_strobe_nxt        = 1'b1;
          out_nxt.inserted      = 1'b1;
          out_nxt.removed_count = 5'(removed_r);
          out_nxt.occupancy     = 5'(occ_r + CNT_W'(1));
          state_nxt             = B_IDLE;
        end else begin
          crd_nxt = crd_r + DIM_W'(1);
        end
      end

      B_RDOUT: begin
        out_strobe_nxt     = 1'b1;
        out_nxt.read_valid = rd_ok_r;
        out_nxt.read_value = (rd_ok_r && rd_cok_r) ? 32'(mem_q_r) : 32'sd0;
        out_nxt.occupancy  = 5'(occ_r);
        state_nxt          = B_IDLE;
      end

      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      valid_r      <= '0;
      occ_r        <= '0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      occ_r        <= occ_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    removed_r <= removed_nxt;
    slot_r    <= slot_nxt;
    dest_r    <= dest_nxt;
    crd_r     <= crd_nxt;
    pidx_r    <= pidx_nxt;
    len_r     <= len_nxt;
    cle_r     <= cle_nxt;
    ele_r     <= ele_nxt;
    keep_r    <= keep_nxt;
    found_r   <= found_nxt;
    rd_ok_r   <= rd_ok_nxt;
    rd_cok_r  <= rd_cok_nxt;
    out_r     <= out_nxt;
    cand_r    <= cand_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy count differs from the number of valid slots");

  a_insert_not_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_r.inserted |-> !out_r.overflow)
    else $error("a word reports both insert and overflow");

  a_read_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_r.read_valid |-> !out_r.inserted && out_r.removed_count == 5'd0)
    else $error("a read word carries insert results");

  a_write_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_WRITE |-> found_r && keep_r)
    else $error("candidate written without a free slot");

endmodule

// File: sv/pareto_frontier_insert_top.sv
// Channel  | Ports                              | Handshake
// ---------+------------------------------------+--------------------------------------
// input    | start, busy, in_item               | word taken when start && !busy
// result   | out_strobe, out_item               | word valid for one cycle at strobe
// config   | psel, penable, pwrite, paddr, ...  | write when psel&penable&pwrite&pready
//
// A final coordinate compares the candidate with every valid slot through the single
// read port of the coordinate memory; a stored candidate then has all MAX_DIM
// coordinates written.
// Reset is synchronous and clears the slot valid bits, counters and queue, not
// the memory. busy is high while the two-word queue is full; results cannot stall.
module pareto_frontier_insert_top #(
  parameter int CAPACITY    = pfi_pkg::CAPACITY_DEF,
  parameter int MAX_DIM     = pfi_pkg::MAX_DIM_DEF,
  parameter int COORD_WIDTH = pfi_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pfi_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output pfi_pkg::out_item_t  out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import pfi_pkg::*;

  logic [3:0] vlen_r, vlen_nxt;
  logic       cfg_write;
  logic       q_push, q_pop, q_full, q_empty;
  q_entry_t   q_din, q_dout;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    vlen_nxt = vlen_r;
    if (cfg_write && paddr[2] == REG_VECTOR_LENGTH) begin
      vlen_nxt = pwdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r <= VLEN_RESET;
    end else begin
      vlen_r <= vlen_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_VECTOR_LENGTH) ? {28'd0, vlen_r} : 32'd0;
  assign busy   = q_full;

  pfi_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .q_full        (q_full),
    .in_item       (in_item),
    .vector_length (vlen_r),
    .q_push        (q_push),
    .q_din         (q_din)
  );

  pfi_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  pfi_back #(
    .CAPACITY    (CAPACITY),
    .MAX_DIM     (MAX_DIM),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_dout     (q_dout),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// File: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pfi_pkg::*;

  localparam int CAPACITY      = CAPACITY_DEF;
  localparam int MAX_DIM       = MAX_DIM_DEF;
  localparam int RANDOM_WORDS  = 500;
  localparam int SETTLE_CYCLES = 300;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PRINT_LIMIT   = 100;

  // Operation code that the block ignores.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] ADDR_VECTOR_LENGTH = 3'd0;

  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;

  typedef enum int {
    MODE_CLUSTER,
    MODE_ANTICHAIN,
    MODE_EXTREME
  } stim_mode_t;

  // Tracks the stored frontier and the candidate being assembled, and
  // predicts the block's result words from them.
  class frontier_tracker;
    logic signed [31:0] entry_coords [CAPACITY][MAX_DIM];
    bit                 slot_used [CAPACITY];
    logic signed [31:0] partial_coords [MAX_DIM];
    int unsigned        next_pos;
    logic [3:0]         length_reg;
    out_item_t          pending_outcomes [$];
    int                 mismatch_count;

    function new();
      foreach (slot_used[s]) slot_used[s] = 1'b0;
      foreach (partial_coords[i]) partial_coords[i] = '0;
      next_pos = 0;
      length_reg = VLEN_RESET;
      mismatch_count = 0;
    endfunction

    function void set_length(logic [3:0] value);
      length_reg = value;
    endfunction

    function int active_length();
      if (length_reg == 0) return 1;
      if (length_reg > MAX_DIM) return MAX_DIM;
      return int'(length_reg);
    endfunction

    function int occupancy();
      int n;
      n = 0;
      foreach (slot_used[s]) n += slot_used[s];
      return n;
    endfunction

    function int outstanding();
      return pending_outcomes.size();
    endfunction

    function void report_mismatch(string msg);
      if (mismatch_count < PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, msg);
      mismatch_count++;
    endfunction

    // Compares the finished candidate with every live entry. Equal vectors
    // count as dominating the candidate, so they are kept and it is dropped.
    function out_item_t close_candidate();
      out_item_t r;
      int        len;
      int        dest;
      int        removed;
      bit        keep;
      bit        cand_le;
      bit        entry_le;
      len = active_length();
      keep = 1'b1;
      dest = -1;
      removed = 0;
      for (int s = 0; s < CAPACITY; s++) begin
        if (!slot_used[s]) begin
          if (dest < 0) dest = s;
        end else begin
          cand_le = 1'b1;
          entry_le = 1'b1;
          for (int i = 0; i < len; i++) begin
            if (partial_coords[i] > entry_coords[s][i]) cand_le = 1'b0;
            else if (partial_coords[i] < entry_coords[s][i]) entry_le = 1'b0;
          end
          if (cand_le) begin
            keep = 1'b0;
          end else if (entry_le) begin
            slot_used[s] = 1'b0;
            removed++;
            if (dest < 0) dest = s;
          end
        end
      end
      r = '0;
      if (keep) begin
        if (dest < 0) begin
          r.overflow = 1'b1;
        end else begin
          for (int i = 0; i < MAX_DIM; i++) begin
            entry_coords[dest][i] = (i < len) ? partial_coords[i] : '0;
          end
          slot_used[dest] = 1'b1;
          r.inserted = 1'b1;
        end
      end
      r.removed_count = 5'(removed);
      r.occupancy = 5'(occupancy());
      return r;
    endfunction

    function void take_word(in_item_t w);
      out_item_t r;
      r = '0;
      case (w.operation)
        OP_COORD: begin
          partial_coords[next_pos] = w.coord_value;
          if (next_pos + 1 >= active_length()) begin
            next_pos = 0;
            pending_outcomes.push_back(close_candidate());
          end else begin
            next_pos++;
          end
        end
        OP_READ: begin
          r.occupancy = 5'(occupancy());
          if (slot_used[w.entry_index]) begin
            r.read_valid = 1'b1;
            r.read_value = entry_coords[w.entry_index][w.coord_index];
          end
          pending_outcomes.push_back(r);
        end
        OP_CLEAR: begin
          foreach (slot_used[s]) slot_used[s] = 1'b0;
          next_pos = 0;
          pending_outcomes.push_back(r);
        end
        default: begin
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("result word %0h with none expected", got));
        return;
      end
      want = pending_outcomes.pop_front();
      compare_field("inserted", 32'(got.inserted), 32'(want.inserted));
      compare_field("removed_count", 32'(got.removed_count), 32'(want.removed_count));
      compare_field("overflow", 32'(got.overflow), 32'(want.overflow));
      compare_field("occupancy", 32'(got.occupancy), 32'(want.occupancy));
      compare_field("read_value", got.read_value, want.read_value);
      compare_field("read_valid", 32'(got.read_valid), 32'(want.read_valid));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_strobe;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  frontier_tracker    frontier;
  int                 words_sent;
  bit                 gaps_off;
  logic signed [31:0] antichain_sum;
  logic signed [31:0] antichain_first;

  pareto_frontier_insert_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) frontier.check_result(out_item);
  end

  function automatic in_item_t make_word(logic [1:0] op, logic signed [31:0] value,
                                         logic [3:0] slot, logic [2:0] coord);
    in_item_t w;
    w.operation = op;
    w.coord_value = value;
    w.entry_index = slot;
    w.coord_index = coord;
    return w;
  endfunction

  // start stays high from one word to the next when there is no gap, so it
  // is only lowered when idle cycles follow.
  task automatic send_word(in_item_t w);
    int gap;
    gap = gaps_off ? 0 : $urandom_range(9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    frontier.take_word(w);
    if (w.operation != OP_UNUSED) words_sent++;
  endtask

  task automatic send_coord(logic signed [31:0] value);
    send_word(make_word(OP_COORD, value, 4'($urandom), 3'($urandom)));
  endtask

  task automatic send_read(logic [3:0] slot, logic [2:0] coord);
    send_word(make_word(OP_READ, $urandom, slot, coord));
  endtask

  task automatic send_clear();
    send_word(make_word(OP_CLEAR, $urandom, 4'($urandom), 3'($urandom)));
  endtask

  task automatic send_noise();
    send_word(make_word(OP_UNUSED, $urandom, 4'($urandom), 3'($urandom)));
  endtask

  task automatic send_vector4(logic signed [31:0] value);
    repeat (4) send_coord(value);
  endtask

  // Waits for every expected word, then long enough for a trailing coordinate
  // word without a result to leave the back end.
  task automatic settle();
    int waited;
    waited = 0;
    while (frontier.outstanding() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(logic [3:0] value);
    logic [31:0] data;
    data = $urandom;
    data[3:0] = value;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_VECTOR_LENGTH;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    frontier.set_length(value);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[3:0] !== value) begin
      frontier.report_mismatch($sformatf("vector_length read %0h expected %0h",
                                         prdata[3:0], value));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_coord(stim_mode_t mode);
    logic signed [31:0] v;
    case (mode)
      MODE_ANTICHAIN: begin
        // The first two coordinates keep a fixed sum, so at a vector length of two or
        // more, vectors with different first coordinates never dominate each other.
        if (frontier.next_pos == 0) begin
          antichain_first = 32'($urandom_range(2000)) - 32'sd1000;
          v = antichain_first;
        end else if (frontier.next_pos == 1) begin
          v = antichain_sum - antichain_first;
        end else begin
          v = 32'($urandom_range(4)) - 32'sd2;
        end
      end
      MODE_EXTREME: begin
        case ($urandom_range(5))
          0: v = COORD_MIN;
          1: v = COORD_MAX;
          2: v = '0;
          3: v = -32'sd1;
          default: v = $urandom;
        endcase
      end
      default: v = 32'($urandom_range(4)) - 32'sd2;
    endcase
    return v;
  endfunction

  task automatic run_phase(stim_mode_t mode, int count);
    int pick;
    antichain_sum = 32'($urandom_range(200)) - 32'sd100;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_noise();
      end else if (pick < 5 && mode != MODE_ANTICHAIN) begin
        send_clear();
      end else if (pick < 22) begin
        send_read(4'($urandom), 3'($urandom));
      end else begin
        send_coord(pick_coord(mode));
      end
    end
    start <= 1'b0;
  endtask

  initial begin
    logic [3:0] new_length;
    stim_mode_t mode;
    int         phase;

    frontier = new();
    words_sent = 0;
    gaps_off = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset length of four.
    send_read(4'd0, 3'd0);
    send_vector4('0);
    send_vector4('0);
    send_vector4(COORD_MAX);
    send_vector4(COORD_MIN);
    send_read(4'd0, 3'd0);
    send_read(4'd0, 3'd7);
    send_noise();
    send_clear();
    send_read(4'd0, 3'd0);
    start <= 1'b0;

    phase = 0;
    while (words_sent < RANDOM_WORDS) begin
      case (phase)
        0: new_length = 4'd1;
        1: new_length = 4'd8;
        2: new_length = 4'd0;
        3: new_length = 4'd15;
        4: new_length = 4'd2;
        default: new_length = 4'($urandom_range(15));
      endcase
      mode = (phase < 6) ? stim_mode_t'(phase % 3) : stim_mode_t'($urandom_range(2));
      gaps_off = ($urandom_range(3) == 0);
      settle();
      write_length(new_length);
      run_phase(mode, $urandom_range(30, 70));
      phase++;
    end

    settle();
    if (frontier.outstanding() != 0) begin
      frontier.report_mismatch($sformatf("%0d expected words never arrived",
                                         frontier.outstanding()));
    end
    if (frontier.mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/pfi_pkg.sv
sv/pfi_front.sv
sv/pfi_queue.sv
sv/pfi_back.sv
sv/pareto_frontier_insert_top.sv
dv/tb_top.sv
